[rtl/longest_descending_grid_path_top_defines.svh]
// ----------------------------------------------------------------------------
// longest_descending_grid_path_top_defines
// assertion macros for the grid path block
// ----------------------------------------------------------------------------
`ifndef LONGEST_DESCENDING_GRID_PATH_TOP_DEFINES_SVH
`define LONGEST_DESCENDING_GRID_PATH_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LDGP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid path assertion failed");

// next-cycle implication, disabled during reset
`define LDGP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid path assertion failed");

`endif

[rtl/ldgp_pkg.sv]
// ----------------------------------------------------------------------------
// ldgp_pkg
// shared sizes, types and helpers of the descending grid path block
// ----------------------------------------------------------------------------
package ldgp_pkg;

	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 128;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int AW       = $clog2(CELLS);
	localparam int NW       = $clog2(CELLS + 1);
	localparam int RW       = $clog2(MAX_ROWS + 1);
	localparam int CW       = $clog2(MAX_COLS + 1);
	localparam int HW       = 16;
	localparam int LW       = 15;
	localparam int CFG_W    = 8;

	typedef logic [LW-1:0] len_t;
	typedef logic [HW-1:0] height_t;
	typedef logic [AW-1:0] addr_t;

	localparam len_t LEN_SAT = '1;

	typedef enum logic [0:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic          start;
		logic          take;
		logic [RW-1:0] rows;
		logic [CW-1:0] cols;
	} eng_cmd_t;

	typedef struct packed {
		logic done;
		len_t best;
	} eng_rsp_t;

	function automatic len_t len_inc(len_t v);
		len_inc = (v == LEN_SAT) ? v : len_t'(v + 1'b1);
	endfunction

	function automatic len_t len_max(len_t a, len_t b);
		len_max = (a > b) ? a : b;
	endfunction

	function automatic logic [RW-1:0] clamp_rows(logic [CFG_W-1:0] v);
		if (v == '0)
			clamp_rows = RW'(1);
		else if (int'(v) > MAX_ROWS)
			clamp_rows = RW'(MAX_ROWS);
		else
			clamp_rows = RW'(v);
	endfunction

	function automatic logic [CW-1:0] clamp_cols(logic [CFG_W-1:0] v);
		if (v == '0)
			clamp_cols = CW'(1);
		else if (int'(v) > MAX_COLS)
			clamp_cols = CW'(MAX_COLS);
		else
			clamp_cols = CW'(v);
	endfunction

endpackage

[rtl/longest_descending_grid_path_top.sv]
// ----------------------------------------------------------------------------
// longest_descending_grid_path_top
// longest strictly descending 4-neighbour path over a loaded height grid
// ----------------------------------------------------------------------------
// Heights load at one beat per cycle in row-major order into an on-chip
// memory. After the beat flagged last_sample the block drops ready and
// works from a length/done memory with one write and one read port: a
// clearing pass over all rows*cols cells, then per cell a scan and, for a
// cell that is walked, a step for each of the four directions and an end
// step, a read and a compare per in-grid neighbour probe, and a pop.
// One result beat follows; loading of the next grid may start while it waits.
module longest_descending_grid_path_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [ldgp_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ldgp_pkg::HW-1:0]      height,
	input  logic                         last_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ldgp_pkg::LW-1:0]      longest_path
);
	import ldgp_pkg::*;

	logic [CFG_W-1:0] rows_cfg_q;
	logic [CFG_W-1:0] cols_cfg_q;
	logic [RW-1:0]    rows_eff;
	logic [CW-1:0]    cols_eff;
	logic [NW-1:0]    n_cells;
	addr_t            load_pos_q;
	addr_t            wr_pos;
	logic             busy_q;
	logic             out_valid_q;
	len_t             result_q;
	logic             in_acc;
	eng_cmd_t         cmd;
	eng_rsp_t         rsp;

	assign rows_eff = clamp_rows(rows_cfg_q);
	assign cols_eff = clamp_cols(cols_cfg_q);
	assign n_cells  = NW'(rows_eff * cols_eff);
	assign wr_pos   = ({1'b0, load_pos_q} >= n_cells) ? '0 : load_pos_q;
	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;

	assign cmd.start = in_acc && last_sample;
	assign cmd.take  = rsp.done && (!out_valid_q || out_ready);
	assign cmd.rows  = rows_eff;
	assign cmd.cols  = cols_eff;

	ldgp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.h_we   (in_acc),
		.h_wa   (wr_pos),
		.h_wd   (height),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= CFG_W'(1);
			cols_cfg_q  <= CFG_W'(1);
			load_pos_q  <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ROWS: rows_cfg_q <= cfg_data;
					REG_COLS: cols_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				if (last_sample || ({1'b0, wr_pos} + 1'b1 >= n_cells))
					load_pos_q <= '0;
				else
					load_pos_q <= addr_t'(wr_pos + 1'b1);
				if (last_sample)
					busy_q <= 1'b1;
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.take) begin
				out_valid_q <= 1'b1;
				result_q    <= rsp.best;
				busy_q      <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign longest_path = result_q;

endmodule

[rtl/ldgp_engine.sv]
// ----------------------------------------------------------------------------
// ldgp_engine
// grid memories and the walk sequencer: clears the length and done stores,
// then settles every cell by a depth-first walk over an explicit stack
// ----------------------------------------------------------------------------
module ldgp_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                h_we,
	input  ldgp_pkg::addr_t     h_wa,
	input  ldgp_pkg::height_t   h_wd,
	input  ldgp_pkg::eng_cmd_t  cmd,
	output ldgp_pkg::eng_rsp_t  rsp
);
	import ldgp_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CLEAR = 10'b0000000010,
		ST_OUTER = 10'b0000000100,
		ST_OWAIT = 10'b0000001000,
		ST_DIR   = 10'b0000010000,
		ST_RD    = 10'b0000100000,
		ST_NB    = 10'b0001000000,
		ST_POP   = 10'b0010000000,
		ST_POPW  = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	typedef enum logic [2:0] {
		DIR_E   = 3'd0,
		DIR_W   = 3'd1,
		DIR_S   = 3'd2,
		DIR_N   = 3'd3,
		DIR_END = 3'd4
	} dir_t;

	typedef struct packed {
		logic [RW-1:0] r;
		logic [CW-1:0] c;
		dir_t          dir;
		len_t          len;
		height_t       h;
	} frame_t;

	height_t hmem [CELLS];
	len_t    lmem [CELLS];
	logic    dmem [CELLS];
	frame_t  smem [CELLS];

	state_t        state_q;
	logic [RW-1:0] rows_q;
	logic [CW-1:0] cols_q;
	logic [NW-1:0] n_q;
	addr_t         oi_q;
	logic [RW-1:0] orow_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] r_q, nr_q;
	logic [CW-1:0] c_q, nc_q;
	dir_t          dir_q;
	len_t          len_q;
	height_t       h_q;
	addr_t         dp_q;
	addr_t         addr_q;
	len_t          best_q;

	height_t       h_rd;
	len_t          l_rd;
	logic          d_rd;
	frame_t        s_rd;

	addr_t         rd_addr;
	logic          l_we;
	addr_t         l_wa;
	len_t          l_wd;
	logic          d_wd;
	logic          s_we;
	logic          s_re;

	logic [RW-1:0]    nr_d;
	logic [CW-1:0]    nc_d;
	logic             nb_ok;
	logic [RW+CW-1:0] prod;
	logic [RW+CW:0]   idx_sum;
	logic             last_cell;

	always_comb begin
		nr_d  = r_q;
		nc_d  = c_q;
		nb_ok = 1'b0;
		case (dir_q)
			DIR_E: begin
				nc_d  = CW'(c_q + 1'b1);
				nb_ok = ({1'b0, c_q} + 1'b1) < {1'b0, cols_q};
			end
			DIR_W: begin
				nc_d  = CW'(c_q - 1'b1);
				nb_ok = (c_q != '0);
			end
			DIR_S: begin
				nr_d  = RW'(r_q + 1'b1);
				nb_ok = ({1'b0, r_q} + 1'b1) < {1'b0, rows_q};
			end
			DIR_N: begin
				nr_d  = RW'(r_q - 1'b1);
				nb_ok = (r_q != '0);
			end
			default: begin
				nr_d  = r_q;
				nc_d  = c_q;
				nb_ok = 1'b0;
			end
		endcase
		prod    = nr_d * cols_q;
		idx_sum = {1'b0, prod} + (RW+CW+1)'(nc_d);
	end

	assign last_cell = ({1'b0, oi_q} == NW'(n_q - 1'b1));

	always_comb begin
		rd_addr = (state_q == ST_OUTER) ? oi_q : addr_q;
		l_we    = 1'b0;
		l_wa    = addr_q;
		l_wd    = len_q;
		d_wd    = 1'b1;
		if (state_q == ST_CLEAR) begin
			l_we = 1'b1;
			l_wa = oi_q;
			l_wd = len_t'(1);
			d_wd = 1'b0;
		end else if (state_q == ST_POP) begin
			l_we = 1'b1;
		end
		s_we = (state_q == ST_NB) && (h_rd < h_q) && !d_rd;
		s_re = (state_q == ST_POP);
	end

	always_ff @(posedge clk) begin
		if (h_we)
			hmem[h_wa] <= h_wd;
		h_rd <= hmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			lmem[l_wa] <= l_wd;
			dmem[l_wa] <= d_wd;
		end
		l_rd <= lmem[rd_addr];
		d_rd <= dmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (s_we)
			smem[dp_q] <= '{r: r_q, c: c_q, dir: dir_q, len: len_q, h: h_q};
		if (s_re)
			s_rd <= smem[addr_t'(dp_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= RW'(1);
			cols_q  <= CW'(1);
			n_q     <= NW'(1);
			oi_q    <= '0;
			orow_q  <= '0;
			ocol_q  <= '0;
			r_q     <= '0;
			c_q     <= '0;
			nr_q    <= '0;
			nc_q    <= '0;
			dir_q   <= DIR_E;
			len_q   <= '0;
			h_q     <= '0;
			dp_q    <= '0;
			addr_q  <= '0;
			best_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						rows_q  <= cmd.rows;
						cols_q  <= cmd.cols;
						n_q     <= NW'(cmd.rows * cmd.cols);
						oi_q    <= '0;
						best_q  <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (last_cell) begin
						oi_q    <= '0;
						orow_q  <= '0;
						ocol_q  <= '0;
						state_q <= ST_OUTER;
					end else begin
						oi_q <= addr_t'(oi_q + 1'b1);
					end
				end
				ST_OUTER: begin
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (d_rd) begin
						best_q <= len_max(best_q, l_rd);
						if (last_cell)
							state_q <= ST_FIN;
						else begin
							oi_q <= addr_t'(oi_q + 1'b1);
							if ({1'b0, ocol_q} + 1'b1 == {1'b0, cols_q}) begin
								ocol_q <= '0;
								orow_q <= RW'(orow_q + 1'b1);
							end else begin
								ocol_q <= CW'(ocol_q + 1'b1);
							end
							state_q <= ST_OUTER;
						end
					end else begin
						r_q     <= orow_q;
						c_q     <= ocol_q;
						dir_q   <= DIR_E;
						len_q   <= l_rd;
						h_q     <= h_rd;
						dp_q    <= '0;
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					addr_q <= AW'(idx_sum);
					nr_q   <= nr_d;
					nc_q   <= nc_d;
					if (dir_q == DIR_END)
						state_q <= ST_POP;
					else begin
						dir_q <= dir_t'(dir_q + 1'b1);
						if (nb_ok)
							state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_NB;
				end
				ST_NB: begin
					if (h_rd < h_q) begin
						if (d_rd)
							len_q <= len_max(len_q, len_inc(l_rd));
						else begin
							dp_q  <= addr_t'(dp_q + 1'b1);
							r_q   <= nr_q;
							c_q   <= nc_q;
							dir_q <= DIR_E;
							len_q <= l_rd;
							h_q   <= h_rd;
						end
					end
					state_q <= ST_DIR;
				end
				ST_POP: begin
					if (dp_q == '0) begin
						best_q <= len_max(best_q, len_q);
						if (last_cell)
							state_q <= ST_FIN;
						else begin
							oi_q <= addr_t'(oi_q + 1'b1);
							if ({1'b0, ocol_q} + 1'b1 == {1'b0, cols_q}) begin
								ocol_q <= '0;
								orow_q <= RW'(orow_q + 1'b1);
							end else begin
								ocol_q <= CW'(ocol_q + 1'b1);
							end
							state_q <= ST_OUTER;
						end
					end else begin
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					r_q     <= s_rd.r;
					c_q     <= s_rd.c;
					dir_q   <= s_rd.dir;
					h_q     <= s_rd.h;
					len_q   <= len_max(s_rd.len, len_inc(len_q));
					dp_q    <= addr_t'(dp_q - 1'b1);
					state_q <= ST_DIR;
				end
				ST_FIN: begin
					if (cmd.take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == ST_FIN);
	assign rsp.best = best_q;

endmodule

[rtl/ldgp_checker.sv]
// ----------------------------------------------------------------------------
// ldgp_checker
// port-level checks of the grid path block, bound to the top level
// ----------------------------------------------------------------------------
`include "longest_descending_grid_path_top_defines.svh"

module ldgp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         last_sample,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ldgp_pkg::LW-1:0]      longest_path
);
	import ldgp_pkg::*;

	// a stalled result beat holds
	`LDGP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(longest_path))
	// the closing beat starts the walk
	`LDGP_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_sample, !in_ready)
	// a path has at least one cell
	`LDGP_ASSERT_NOW(a_out_nonzero, out_valid, longest_path != '0)
	// no path longer than the grid
	`LDGP_ASSERT_NOW(a_out_bound, out_valid, longest_path <= LW'(CELLS))

endmodule

bind longest_descending_grid_path_top ldgp_checker u_ldgp_checker (.*);
